// File: rtl/gpd_pkg.sv
// ----------------------------------------------------------------------------
// gpd_pkg
// Shared types and constants for the grid point deposit unit.
// ----------------------------------------------------------------------------
package gpd_pkg;

  localparam int GRID_X_DEF = 32;
  localparam int GRID_Y_DEF = 32;
  localparam int GRID_Z_DEF = 32;

  localparam int CELL_W  = 48;
  localparam int COORD_W = 32;
  localparam int IDX_W   = 5;
  localparam int MUL_W   = 34;

  typedef enum logic [1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_DEPOSIT = 2'd1,
    KIND_READ    = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_INTERP  = 3'd0,
    REG_COMBINE = 3'd1,
    REG_ORG_X   = 3'd2,
    REG_ORG_Y   = 3'd3,
    REG_ORG_Z   = 3'd4,
    REG_INV_X   = 3'd5,
    REG_INV_Y   = 3'd6,
    REG_INV_Z   = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_MX,
    ST_MY,
    ST_MZ,
    ST_MZW,
    ST_W1,
    ST_W2,
    ST_W3,
    ST_RD,
    ST_WR,
    ST_RRD,
    ST_RDAT
  } state_t;

  typedef struct packed {
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_op_t;

endpackage

// File: rtl/gpd_in_if.sv
// ----------------------------------------------------------------------------
// gpd_in_if
// Item channel into the grid point deposit unit.
// ----------------------------------------------------------------------------
interface gpd_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] point_value;
  logic [4:0]         cell_x;
  logic [4:0]         cell_y;
  logic [4:0]         cell_z;

  modport source (output valid, kind, pos_x, pos_y, pos_z, point_value,
                  cell_x, cell_y, cell_z, input ready);
  modport sink (input valid, kind, pos_x, pos_y, pos_z, point_value,
                cell_x, cell_y, cell_z, output ready);
endinterface

// File: rtl/gpd_out_if.sv
// ----------------------------------------------------------------------------
// gpd_out_if
// Result channel out of the grid point deposit unit.
// ----------------------------------------------------------------------------
interface gpd_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] cell_value;

  modport source (output valid, cell_value, input ready);
  modport sink (input valid, cell_value, output ready);
endinterface

// File: rtl/grid_point_deposit_unit.sv
// ----------------------------------------------------------------------------
// grid_point_deposit_unit
// Deposits point values onto a 3D grid of 48-bit cells held in one RAM.
// ----------------------------------------------------------------------------
// Items enter on in_s (valid/ready); a transfer happens when both are high.
// A clear item zeroes the grid, a deposit item scatters its value into one
// cell (nearest) or eight corners (trilinear), a read item returns one cell
// on out_s. Only read items produce a result.
// One item is worked at a time; in_s.ready is high only while idle.
// Steps from a transfer until the next item can be taken:
//   read            a RAM read, then the result into the output register
//   nearest deposit three axis multiplies, then a RAM read and a write, both
//                   skipped when the cell lies outside the grid
//   trilinear       the three axis multiplies, then per corner three chained
//                   multiplies, a read and a write (skipped outside the grid)
//   clear           one zero write to each of the GRID_X*GRID_Y*GRID_Z cells
// The one multiplier is shared by all of the multiply steps.
// After reset the same clearing pass runs before the first item is taken.
// A waiting result sits in the output register; the block keeps taking new
// items, and a following read holds in its last step until out_s is free.
// Configuration goes through the APB port at any time the block is idle.
// ----------------------------------------------------------------------------
module grid_point_deposit_unit #(
  parameter int GRID_X = gpd_pkg::GRID_X_DEF,
  parameter int GRID_Y = gpd_pkg::GRID_Y_DEF,
  parameter int GRID_Z = gpd_pkg::GRID_Z_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  gpd_in_if.sink      in_s,
  gpd_out_if.source   out_s,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
  localparam int AW    = $clog2(CELLS);
  localparam int XW    = $clog2(GRID_X);
  localparam int YW    = $clog2(GRID_Y);
  localparam int ZW    = $clog2(GRID_Z);
  localparam int CW    = gpd_pkg::CELL_W;
  localparam int MW    = gpd_pkg::MUL_W;

  // configuration registers
  logic        interp_r;
  logic        combine_r;
  logic [31:0] org_x_r, org_y_r, org_z_r;
  logic [31:0] inv_x_r, inv_y_r, inv_z_r;
  logic        cfg_wr;
  gpd_pkg::reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = gpd_pkg::reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interp_r  <= 1'b0;
      combine_r <= 1'b0;
      org_x_r   <= '0;
      org_y_r   <= '0;
      org_z_r   <= '0;
      inv_x_r   <= 32'h0001_0000;
      inv_y_r   <= 32'h0001_0000;
      inv_z_r   <= 32'h0001_0000;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        gpd_pkg::REG_INTERP:  interp_r  <= cfg_pwdata[0];
        gpd_pkg::REG_COMBINE: combine_r <= cfg_pwdata[0];
        gpd_pkg::REG_ORG_X:   org_x_r   <= cfg_pwdata;
        gpd_pkg::REG_ORG_Y:   org_y_r   <= cfg_pwdata;
        gpd_pkg::REG_ORG_Z:   org_z_r   <= cfg_pwdata;
        gpd_pkg::REG_INV_X:   inv_x_r   <= cfg_pwdata;
        gpd_pkg::REG_INV_Y:   inv_y_r   <= cfg_pwdata;
        gpd_pkg::REG_INV_Z:   inv_z_r   <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      gpd_pkg::REG_INTERP:  cfg_prdata = {31'd0, interp_r};
      gpd_pkg::REG_COMBINE: cfg_prdata = {31'd0, combine_r};
      gpd_pkg::REG_ORG_X:   cfg_prdata = org_x_r;
      gpd_pkg::REG_ORG_Y:   cfg_prdata = org_y_r;
      gpd_pkg::REG_ORG_Z:   cfg_prdata = org_z_r;
      gpd_pkg::REG_INV_X:   cfg_prdata = inv_x_r;
      gpd_pkg::REG_INV_Y:   cfg_prdata = inv_y_r;
      gpd_pkg::REG_INV_Z:   cfg_prdata = inv_z_r;
      default:              cfg_prdata = '0;
    endcase
  end

  // control state
  gpd_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [2:0]      corner_r, corner_nxt;
  logic            out_valid_r, out_valid_nxt;

  // item payload
  logic signed [32:0] dx_r, dy_r, dz_r;
  logic [31:0]        mag_r;
  logic               neg_r;
  logic signed [31:0] val_r;
  logic [4:0]         rx_r, ry_r, rz_r;
  logic signed [32:0] ix_r, iy_r, iz_r;
  logic [15:0]        fx_r, fy_r, fz_r;
  logic signed [CW-1:0] contrib_r;
  logic [AW-1:0]      addr_r;
  logic               rd_ok_r;
  logic signed [CW-1:0] out_val_r;

  logic in_xfer;
  assign in_xfer    = in_s.valid && in_s.ready;
  assign in_s.ready = (state_r == gpd_pkg::ST_IDLE);
  assign out_s.valid      = out_valid_r;
  assign out_s.cell_value = out_val_r;

  // multiplier
  gpd_pkg::mul_op_t     mul_op;
  logic signed [2*MW-1:0] mul_p;

  gpd_mul u_mul (
    .clk (clk),
    .op  (mul_op),
    .p   (mul_p)
  );

  // round-half-up of a Q.16 product back to integer
  logic [49:0] rnd_sum;
  logic [33:0] rnd_v;
  assign rnd_sum = mul_p[49:0] + 50'd32768;
  assign rnd_v   = rnd_sum[49:16];

  // corner weights
  logic        cx, cy, cz;
  logic [16:0] wx, wy, wz;
  assign cx = corner_r[2];
  assign cy = corner_r[1];
  assign cz = corner_r[0];
  assign wx = cx ? {1'b0, fx_r} : 17'h1_0000 - {1'b0, fx_r};
  assign wy = cy ? {1'b0, fy_r} : 17'h1_0000 - {1'b0, fy_r};
  assign wz = cz ? {1'b0, fz_r} : 17'h1_0000 - {1'b0, fz_r};

  // target cell of the current corner
  logic        off_x, off_y, off_z;
  logic [33:0] sx, sy, sz;
  logic        in_grid;
  logic [AW-1:0] cell_addr;

  assign off_x = interp_r ? cx : (fx_r > 16'h8000);
  assign off_y = interp_r ? cy : (fy_r > 16'h8000);
  assign off_z = interp_r ? cz : (fz_r > 16'h8000);
  assign sx = {ix_r[32], ix_r} + {33'd0, off_x};
  assign sy = {iy_r[32], iy_r} + {33'd0, off_y};
  assign sz = {iz_r[32], iz_r} + {33'd0, off_z};
  assign in_grid = !sx[33] && (sx[32:0] < 33'(GRID_X)) &&
                   !sy[33] && (sy[32:0] < 33'(GRID_Y)) &&
                   !sz[33] && (sz[32:0] < 33'(GRID_Z));
  assign cell_addr = AW'((AW'(sx[XW-1:0]) * AW'(GRID_Y) + AW'(sy[YW-1:0])) * AW'(GRID_Z)
                         + AW'(sz[ZW-1:0]));

  // read item address
  logic          rd_in_grid;
  logic [AW-1:0] rd_addr;
  assign rd_in_grid = (int'(rx_r) < GRID_X) && (int'(ry_r) < GRID_Y) &&
                      (int'(rz_r) < GRID_Z);
  assign rd_addr = AW'((AW'(rx_r) * AW'(GRID_Y) + AW'(ry_r)) * AW'(GRID_Z) + AW'(rz_r));

  // contribution of the current corner
  logic signed [CW-1:0] tri_contrib;
  logic [CW-1:0]        tri_mag;
  assign tri_mag     = {16'd0, rnd_v[31:0]};
  assign tri_contrib = neg_r ? -$signed(tri_mag) : $signed(tri_mag);

  // grid RAM
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [CW-1:0] ram_wdata, ram_rdata;
  logic signed [CW-1:0] merged;

  gpd_ram #(
    .WIDTH (CW),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gpd_combine u_comb (
    .mode     (combine_r),
    .cell_val ($signed(ram_rdata)),
    .contrib  (contrib_r),
    .result   (merged)
  );

  logic last_corner;
  assign last_corner = !interp_r || (corner_r == 3'd7);

  // next state and control
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    corner_nxt    = corner_r;
    out_valid_nxt = out_valid_r && !out_s.ready;
    ram_we        = 1'b0;
    ram_waddr     = addr_r;
    ram_wdata     = merged;
    ram_re        = 1'b0;
    ram_raddr     = cell_addr;
    mul_op.a      = '0;
    mul_op.b      = '0;
    unique case (state_r)
      gpd_pkg::ST_IDLE: begin
        corner_nxt = 3'd0;
        if (in_xfer) begin
          unique case (gpd_pkg::kind_t'(in_s.kind))
            gpd_pkg::KIND_CLEAR:   state_nxt = gpd_pkg::ST_CLR;
            gpd_pkg::KIND_DEPOSIT: state_nxt = gpd_pkg::ST_MX;
            gpd_pkg::KIND_READ:    state_nxt = gpd_pkg::ST_RRD;
            default:               state_nxt = gpd_pkg::ST_IDLE;
          endcase
        end
      end
      gpd_pkg::ST_CLR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(CELLS - 1)) begin
          clr_cnt_nxt = '0;
          state_nxt   = gpd_pkg::ST_IDLE;
        end
      end
      gpd_pkg::ST_MX: begin
        mul_op.a  = MW'(dx_r);
        mul_op.b  = {2'b00, inv_x_r};
        state_nxt = gpd_pkg::ST_MY;
      end
      gpd_pkg::ST_MY: begin
        mul_op.a  = MW'(dy_r);
        mul_op.b  = {2'b00, inv_y_r};
        state_nxt = gpd_pkg::ST_MZ;
      end
      gpd_pkg::ST_MZ: begin
        mul_op.a  = MW'(dz_r);
        mul_op.b  = {2'b00, inv_z_r};
        state_nxt = gpd_pkg::ST_MZW;
      end
      gpd_pkg::ST_MZW: begin
        state_nxt = interp_r ? gpd_pkg::ST_W1 : gpd_pkg::ST_RD;
      end
      gpd_pkg::ST_W1: begin
        mul_op.a  = {17'd0, wx};
        mul_op.b  = {17'd0, wy};
        state_nxt = gpd_pkg::ST_W2;
      end
      gpd_pkg::ST_W2: begin
        mul_op.a  = rnd_v;
        mul_op.b  = {17'd0, wz};
        state_nxt = gpd_pkg::ST_W3;
      end
      gpd_pkg::ST_W3: begin
        mul_op.a  = rnd_v;
        mul_op.b  = {2'b00, mag_r};
        state_nxt = gpd_pkg::ST_RD;
      end
      gpd_pkg::ST_RD: begin
        if (in_grid) begin
          ram_re    = 1'b1;
          state_nxt = gpd_pkg::ST_WR;
        end else if (last_corner) begin
          state_nxt = gpd_pkg::ST_IDLE;
        end else begin
          corner_nxt = corner_r + 3'd1;
          state_nxt  = gpd_pkg::ST_W1;
        end
      end
      gpd_pkg::ST_WR: begin
        ram_we = 1'b1;
        if (last_corner) begin
          state_nxt = gpd_pkg::ST_IDLE;
        end else begin
          corner_nxt = corner_r + 3'd1;
          state_nxt  = gpd_pkg::ST_W1;
        end
      end
      gpd_pkg::ST_RRD: begin
        ram_re    = 1'b1;
        ram_raddr = rd_addr;
        state_nxt = gpd_pkg::ST_RDAT;
      end
      gpd_pkg::ST_RDAT: begin
        // hold the read until the output register is free
        if (!out_valid_r || out_s.ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = gpd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gpd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gpd_pkg::ST_CLR;
      clr_cnt_r   <= '0;
      corner_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      corner_r    <= corner_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      dx_r  <= {in_s.pos_x[31], in_s.pos_x} - {org_x_r[31], org_x_r};
      dy_r  <= {in_s.pos_y[31], in_s.pos_y} - {org_y_r[31], org_y_r};
      dz_r  <= {in_s.pos_z[31], in_s.pos_z} - {org_z_r[31], org_z_r};
      val_r <= in_s.point_value;
      neg_r <= in_s.point_value[31];
      mag_r <= in_s.point_value[31] ? 32'(-{1'b1, in_s.point_value})
                                    : 32'(in_s.point_value);
      rx_r  <= in_s.cell_x;
      ry_r  <= in_s.cell_y;
      rz_r  <= in_s.cell_z;
    end
    // the product lands in the cycle after its operands
    if (state_r == gpd_pkg::ST_MY) begin
      ix_r <= mul_p[64:32];
      fx_r <= mul_p[31:16];
    end
    if (state_r == gpd_pkg::ST_MZ) begin
      iy_r <= mul_p[64:32];
      fy_r <= mul_p[31:16];
    end
    if (state_r == gpd_pkg::ST_MZW) begin
      iz_r <= mul_p[64:32];
      fz_r <= mul_p[31:16];
    end
    if (state_r == gpd_pkg::ST_RD) begin
      contrib_r <= interp_r ? tri_contrib : CW'(val_r);
      addr_r    <= cell_addr;
    end
    if (state_r == gpd_pkg::ST_RRD) begin
      rd_ok_r <= rd_in_grid;
    end
    if (state_r == gpd_pkg::ST_RDAT && (!out_valid_r || out_s.ready)) begin
      out_val_r <= rd_ok_r ? $signed(ram_rdata) : '0;
    end
  end

endmodule

// File: rtl/gpd_ram.sv
// ----------------------------------------------------------------------------
// gpd_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module gpd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32768,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/gpd_mul.sv
// ----------------------------------------------------------------------------
// gpd_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module gpd_mul (
  input  logic                                clk,
  input  gpd_pkg::mul_op_t                    op,
  output logic signed [2*gpd_pkg::MUL_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= op.a * op.b;
  end

endmodule

// File: rtl/gpd_combine.sv
// ----------------------------------------------------------------------------
// gpd_combine
// Merges a contribution into a cell: saturating add or larger magnitude.
// ----------------------------------------------------------------------------
module gpd_combine (
  input  logic                                 mode,
  input  logic signed [gpd_pkg::CELL_W-1:0]    cell_val,
  input  logic signed [gpd_pkg::CELL_W-1:0]    contrib,
  output logic signed [gpd_pkg::CELL_W-1:0]    result
);

  localparam int W = gpd_pkg::CELL_W;

  logic signed [W:0] sum;
  logic [W:0]        abs_cell;
  logic [W:0]        abs_contrib;
  logic signed [W-1:0] sat_sum;

  always_comb begin
    sum         = {cell_val[W-1], cell_val} + {contrib[W-1], contrib};
    abs_cell    = cell_val[W-1] ? -{cell_val[W-1], cell_val} : {cell_val[W-1], cell_val};
    abs_contrib = contrib[W-1] ? -{contrib[W-1], contrib} : {contrib[W-1], contrib};
    // overflow when the two top bits of the grown sum differ
    if (sum[W] != sum[W-1]) begin
      sat_sum = sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      sat_sum = sum[W-1:0];
    end
    if (mode) begin
      result = (abs_contrib > abs_cell) ? contrib : cell_val;
    end else begin
      result = sat_sum;
    end
  end

endmodule

// File: rtl/gpd_checker.sv
// ----------------------------------------------------------------------------
// gpd_checker
// Port-level checks on the grid point deposit unit, bound to the top level.
// ----------------------------------------------------------------------------
module gpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_kind,
  input logic        out_valid,
  input logic        out_ready,
  input logic [47:0] out_value
);

  // a result stays offered until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_value))
    else $error("result changed while stalled");

  // one item at a time: no transfer right after a transfer that starts work
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind != gpd_pkg::KIND_NONE) |=> !in_ready)
    else $error("input taken while busy");

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind grid_point_deposit_unit gpd_checker u_gpd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_s.valid),
  .in_ready  (in_s.ready),
  .in_kind   (in_s.kind),
  .out_valid (out_s.valid),
  .out_ready (out_s.ready),
  .out_value (out_s.cell_value)
);

// File: tb/sv/tb_grid_point_deposit_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_point_deposit_unit
// Checks deposits, clears and cell reads against a behavioural grid mirror.
// Each accepted item updates the mirror; reads queue the expected cell value,
// which is compared with each result transfer. Register settings, idling on
// both channels and a long receiver hold-off vary between the test tasks.
// ----------------------------------------------------------------------------
module tb_grid_point_deposit_unit;
  import gpd_pkg::*;

  localparam int  NX = 32, NY = 32, NZ = 32;
  localparam int  DRAIN_CYCLES = 60;
  localparam longint CYCLE_LIMIT = 1500000;
  localparam longint CELL_MAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint CELL_MIN = -64'sh8000_0000_0000;

  typedef struct {
    kind_t              kind;
    logic signed [31:0] px, py, pz, val;
    logic [4:0]         cx, cy, cz;
  } item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  gpd_in_if  in_ch ();
  gpd_out_if out_ch ();

  grid_point_deposit_unit i_dut (
    .clk(clk), .rst_n(rst_n), .in_s(in_ch.sink), .out_s(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mirror of the block's registers and grid
  logic               m_interp, m_combine;
  logic signed [31:0] m_org [3];
  logic [31:0]        m_inv [3];
  longint             grid_mirror [NX*NY*NZ];
  longint             cell_values_due [$];

  int     fail_count = 0;
  longint cycle_count = 0;
  int     idle_mode = 0;    // 0 none, 1 sender, 2 receiver, 3 both
  int     hold_left = 0;
  int     last_x = 0, last_y = 0, last_z = 0;

  task automatic report(input string what);
    fail_count++;
    $display("mismatch: %s", what);
  endtask

  function automatic void clear_mirror();
    foreach (grid_mirror[i]) grid_mirror[i] = 0;
  endfunction

  function automatic void map_axis(input logic signed [31:0] pos, input logic signed [31:0] org,
                                   input logic [31:0] inv, output longint idx,
                                   output logic [15:0] frac);
    longint     d;
    logic [63:0] mag, m;
    logic [31:0] lo;
    d = longint'(pos) - longint'(org);
    mag = (d < 0) ? 64'(-d) : 64'(d);
    m = mag * 64'(inv);
    lo = m[31:0];
    if (d >= 0) begin
      idx = longint'(m[63:32]);
      frac = m[31:16];
    end else begin
      idx = -longint'(m[63:32]) - ((lo != 0) ? 1 : 0);
      frac = 16'((32'h0 - lo) >> 16);
    end
  endfunction

  function automatic longint mag_of(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void deposit_cell(input longint x, input longint y, input longint z,
                                       input longint v);
    int     a;
    longint s;
    if (x < 0 || x >= NX || y < 0 || y >= NY || z < 0 || z >= NZ) return;
    a = int'((x * NY + y) * NZ + z);
    if (!m_combine) begin
      s = grid_mirror[a] + v;
      if (s > CELL_MAX) s = CELL_MAX;
      if (s < CELL_MIN) s = CELL_MIN;
      grid_mirror[a] = s;
    end else if (mag_of(v) > mag_of(grid_mirror[a])) begin
      grid_mirror[a] = v;
    end
  endfunction

  function automatic void deposit_point(input item_t it);
    longint      ix, iy, iz, val, r;
    logic [15:0] fx, fy, fz;
    logic [63:0] wx, wy, wz, wxy, w, mag;
    val = longint'(it.val);
    map_axis(it.px, m_org[0], m_inv[0], ix, fx);
    map_axis(it.py, m_org[1], m_inv[1], iy, fy);
    map_axis(it.pz, m_org[2], m_inv[2], iz, fz);
    if (!m_interp) begin
      deposit_cell(ix + (fx > 16'h8000), iy + (fy > 16'h8000), iz + (fz > 16'h8000), val);
    end else begin
      mag = 64'(mag_of(val));
      for (int cx = 0; cx < 2; cx++) begin
        wx = cx ? 64'(fx) : 64'd65536 - fx;
        for (int cy = 0; cy < 2; cy++) begin
          wy = cy ? 64'(fy) : 64'd65536 - fy;
          wxy = (wx * wy + 64'd32768) >> 16;
          for (int cz = 0; cz < 2; cz++) begin
            wz = cz ? 64'(fz) : 64'd65536 - fz;
            w = (wxy * wz + 64'd32768) >> 16;
            r = longint'((mag * w + 64'd32768) >> 16);
            deposit_cell(ix + cx, iy + cy, iz + cz, (val < 0) ? -r : r);
          end
        end
      end
    end
  endfunction

  // updates the mirror for one accepted item
  function automatic void apply_item(input item_t it);
    case (it.kind)
      KIND_CLEAR:   clear_mirror();
      KIND_DEPOSIT: deposit_point(it);
      KIND_READ:    cell_values_due.push_back(
                      grid_mirror[(int'(it.cx) * NY + int'(it.cy)) * NZ + int'(it.cz)]);
      default: ;
    endcase
  endfunction

  task automatic send_item(input item_t it);
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.kind = it.kind;
    in_ch.pos_x = it.px;
    in_ch.pos_y = it.py;
    in_ch.pos_z = it.pz;
    in_ch.point_value = it.val;
    in_ch.cell_x = it.cx;
    in_ch.cell_y = it.cy;
    in_ch.cell_z = it.cz;
    do @(posedge clk); while (!in_ch.ready);
    apply_item(it);
    if ((idle_mode == 1 && $urandom_range(99) < 68) ||
        (idle_mode == 3 && $urandom_range(99) < 16)) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      while ($urandom_range(99) < (idle_mode == 1 ? 68 : 16)) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (cell_values_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t r, input logic [31:0] v);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = 5'(r) << 2;
    cfg_pwdata = v;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    case (r)
      REG_INTERP:  m_interp = v[0];
      REG_COMBINE: m_combine = v[0];
      REG_ORG_X:   m_org[0] = v;
      REG_ORG_Y:   m_org[1] = v;
      REG_ORG_Z:   m_org[2] = v;
      REG_INV_X:   m_inv[0] = v;
      REG_INV_Y:   m_inv[1] = v;
      REG_INV_Z:   m_inv[2] = v;
      default: ;
    endcase
  endtask

  task automatic set_all(input logic interp, input logic comb,
                         input logic [31:0] org, input logic [31:0] inv);
    wait_idle();
    write_reg(REG_INTERP, {31'($urandom), interp});
    write_reg(REG_COMBINE, {31'($urandom), comb});
    write_reg(REG_ORG_X, org);
    write_reg(REG_ORG_Y, org);
    write_reg(REG_ORG_Z, org);
    write_reg(REG_INV_X, inv);
    write_reg(REG_INV_Y, inv);
    write_reg(REG_INV_Z, inv);
  endtask

  function automatic item_t make_item(input kind_t k, input logic signed [31:0] x,
                                      input logic signed [31:0] y, input logic signed [31:0] z,
                                      input logic signed [31:0] v);
    item_t it;
    it.kind = k;
    it.px = x; it.py = y; it.pz = z; it.val = v;
    it.cx = 5'($urandom); it.cy = 5'($urandom); it.cz = 5'($urandom);
    return it;
  endfunction

  function automatic item_t read_at(input int x, input int y, input int z);
    item_t it;
    it = make_item(KIND_READ, $urandom, $urandom, $urandom, $urandom);
    it.cx = 5'(x); it.cy = 5'(y); it.cz = 5'(z);
    return it;
  endfunction

  // position near the grid along one axis, in the current scale
  function automatic logic [31:0] rand_pos(input int ax);
    logic [63:0] span;
    longint      off;
    if (m_inv[ax] == 0 || $urandom_range(99) < 8) return $urandom;
    span = (64'd1 << 32) / m_inv[ax];
    if (span > 64'd100000000) span = 64'd100000000;
    off = longint'($urandom_range(0, 35 * 64)) * longint'(span) / 64 - longint'(span);
    return 32'(longint'(m_org[ax]) + off);
  endfunction

  function automatic item_t rand_item();
    item_t       it;
    int          sel;
    longint      ix;
    logic [15:0] fr;
    sel = $urandom_range(99);
    if (sel < 78) begin
      it = make_item(KIND_DEPOSIT, rand_pos(0), rand_pos(1), rand_pos(2),
                     ($urandom_range(1) != 0) ? $urandom : 32'($signed($urandom_range(0, 1 << 20)) -
                                                      (1 << 19)));
      map_axis(it.px, m_org[0], m_inv[0], ix, fr); last_x = int'(ix);
      map_axis(it.py, m_org[1], m_inv[1], ix, fr); last_y = int'(ix);
      map_axis(it.pz, m_org[2], m_inv[2], ix, fr); last_z = int'(ix);
    end else if (sel < 97) begin
      if ($urandom_range(3) != 0)
        it = read_at(last_x + $urandom_range(1), last_y + $urandom_range(1),
                     last_z + $urandom_range(1));
      else
        it = read_at($urandom_range(31), $urandom_range(31), $urandom_range(31));
    end else begin
      it = make_item(KIND_NONE, $urandom, $urandom, $urandom, $urandom);
    end
    return it;
  endfunction

  // receiver side: random stalls plus the long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_mode == 2) begin
      out_ch.ready <= ($urandom_range(99) >= 68);
    end else if (idle_mode == 3) begin
      out_ch.ready <= ($urandom_range(99) >= 16);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (cell_values_due.size() == 0) begin
        report($sformatf("unexpected result cell_value=%0d", out_ch.cell_value));
      end else begin
        longint want;
        want = cell_values_due.pop_front();
        if (out_ch.cell_value !== 48'(want))
          report($sformatf("cell_value got %0d want %0d", out_ch.cell_value, want));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL grid_point_deposit_unit");
      $finish;
    end
  end

  task automatic test_reset_state();
    send_item(read_at(0, 0, 0));
    send_item(read_at(31, 31, 31));
    send_item(make_item(KIND_NONE, $urandom, $urandom, $urandom, $urandom));
  endtask

  task automatic test_nearest_add();
    set_all(1'b0, 1'b0, 32'h0, 32'h0001_0000);
    // fraction exactly one half stays low, just above goes up
    send_item(make_item(KIND_DEPOSIT, 32'h0003_8000, 32'h0003_8001, 32'h0, 32'h7FFF_FFFF));
    send_item(make_item(KIND_DEPOSIT, 32'h0003_8000, 32'h0003_8001, 32'h0, 32'h8000_0000));
    send_item(make_item(KIND_DEPOSIT, 32'h001F_0000, 32'h001F_7FFF, 32'h001F_8000, 32'h1234));
    // outside the grid, negative and past the top
    send_item(make_item(KIND_DEPOSIT, 32'hFFFF_0000, 32'h0, 32'h0, 32'h55));
    send_item(make_item(KIND_DEPOSIT, 32'h0020_0000, 32'h0, 32'h0, 32'h55));
    send_item(read_at(3, 4, 0));
    send_item(read_at(31, 31, 31));
    send_item(read_at(0, 0, 0));
  endtask

  task automatic test_trilinear_max();
    set_all(1'b1, 1'b1, 32'hFFFF_8000, 32'h0002_0000);
    send_item(make_item(KIND_DEPOSIT, 32'h0001_2345, 32'h0000_1000, 32'hFFFF_9000, 32'hFFF0_0000));
    send_item(make_item(KIND_DEPOSIT, 32'h0001_2345, 32'h0000_1000, 32'hFFFF_9000, 32'h0000_0100));
    send_item(make_item(KIND_DEPOSIT, 32'h0001_2345, 32'h0000_1000, 32'hFFFF_9000, 32'h0000_0000));
    send_item(read_at(3, 1, 0));
    send_item(read_at(2, 1, 0));
    send_item(read_at(3, 2, 1));
  endtask

  task automatic test_extreme_regs();
    set_all(1'b0, 1'b0, 32'h8000_0000, 32'h0);
    send_item(make_item(KIND_DEPOSIT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h77));
    send_item(read_at(0, 0, 0));
    set_all(1'b1, 1'b0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_item(make_item(KIND_DEPOSIT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_item(make_item(KIND_DEPOSIT, 32'h8000_0000, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h1));
    send_item(read_at(0, 0, 0));
    send_item(make_item(KIND_CLEAR, $urandom, $urandom, $urandom, $urandom));
    send_item(read_at(0, 0, 0));
  endtask

  task automatic test_random_phase(input int mode, input logic interp, input logic comb,
                                   input logic [31:0] inv, input int count);
    set_all(interp, comb, 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19)), inv);
    idle_mode = mode;
    for (int n = 0; n < count; n++) send_item(rand_item());
    idle_mode = 0;
  endtask

  task automatic test_backpressure();
    set_all(1'b0, 1'b0, 32'h0, 32'h0001_0000);
    send_item(make_item(KIND_DEPOSIT, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 32'h42));
    hold_left = 400;
    for (int n = 0; n < 12; n++)
      send_item((n % 2) ? read_at(2, 2, 2) : rand_item());
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_NONE;
    in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.pos_z = '0;
    in_ch.point_value = '0;
    in_ch.cell_x = '0; in_ch.cell_y = '0; in_ch.cell_z = '0;
    out_ch.ready = 1'b1;
    m_interp = 1'b0;
    m_combine = 1'b0;
    foreach (m_org[i]) m_org[i] = '0;
    foreach (m_inv[i]) m_inv[i] = 32'h0001_0000;
    clear_mirror();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_nearest_add();
    test_trilinear_max();
    test_extreme_regs();
    test_random_phase(0, 1'b0, 1'b0, 32'h0001_0000, 200);
    test_random_phase(1, 1'b1, 1'b0, 32'h0002_0000, 200);
    test_random_phase(2, 1'b1, 1'b1, 32'h0000_8000, 200);
    test_random_phase(3, 1'b0, 1'b1, 32'h0001_8000, 200);
    test_backpressure();

    wait_idle();
    if (fail_count == 0) begin
      $display("PASS grid_point_deposit_unit");
    end else begin
      $display("FAIL grid_point_deposit_unit");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/gpd_pkg.sv
rtl/gpd_in_if.sv
rtl/gpd_out_if.sv
rtl/gpd_ram.sv
rtl/gpd_mul.sv
rtl/gpd_combine.sv
rtl/grid_point_deposit_unit.sv
rtl/gpd_checker.sv
tb/sv/tb_grid_point_deposit_unit.sv
